FILE: sv/tdp_pkg.sv
// shared widths and constants of the trial division primality tester
`default_nettype none

package tdp_pkg;

    // word width of the tested value
    localparam int VALUE_WIDTH = 32;

    // width of the candidate field on the input channel
    localparam int CAND_W = 32;

    // bits that take part in the test after masking to the word width
    localparam int NUM_W = (VALUE_WIDTH < CAND_W) ? VALUE_WIDTH : CAND_W;

    // trial divisor width, holds one step past the square root of the largest value
    localparam int DIV_W = (NUM_W + 1) / 2 + 1;

    // running square of the divisor
    localparam int SQ_W = 2 * DIV_W;

    // bit index used by the serial remainder
    localparam int BIT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    // first odd trial divisor and its square
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
    localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);

    // smallest prime
    localparam logic [NUM_W-1:0] TWO = NUM_W'(2);

endpackage : tdp_pkg

`default_nettype wire

FILE: sv/tdp_if.sv
// valid/ready channel interfaces for candidate and result transfers
`default_nettype none

interface tdp_cand_if;
    import tdp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] candidate_value;

    modport source (output valid, output candidate_value, input ready);
    modport sink   (input valid, input candidate_value, output ready);
endinterface : tdp_cand_if

interface tdp_res_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface : tdp_res_if

`default_nettype wire

FILE: sv/trial_division_primality.sv
// trial division primality tester with a shared serial remainder unit
// values below two and even values go straight to the verdict; odd values pass through S_CHECK,
//   then for each odd trial divisor d with d*d <= n through the bit-serial divider in S_DIV and the check in S_NEXT
// throughput: one candidate at a time, the next transfer is taken once the result is registered
// reset: synchronous active low, clears the sequencer and the result valid, payload is not reset
`default_nettype none

module trial_division_primality (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tdp_cand_if.sink   i_cand,
    tdp_res_if.source  o_res
);
    import tdp_pkg::*;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,  // waiting for a candidate
        S_CHECK = 5'b00010,  // compare divisor square against n
        S_DIV   = 5'b00100,  // serial remainder, one bit per cycle
        S_NEXT  = 5'b01000,  // look at the remainder, step the divisor
        S_FIN   = 5'b10000   // hand the verdict to the output register
    } t_state;

    t_state           r_state, n_state;
    logic [NUM_W-1:0] r_num,   n_num;    // masked candidate
    logic [DIV_W-1:0] r_div,   n_div;    // current odd trial divisor
    logic [SQ_W-1:0]  r_sq,    n_sq;     // r_div squared, kept incrementally
    logic [DIV_W-1:0] r_rem,   n_rem;    // partial remainder
    logic [BIT_W-1:0] r_bit,   n_bit;    // dividend bit being shifted in
    logic             r_res,   n_res;    // pending verdict
    logic             r_out_valid, n_out_valid;
    logic             r_out_flag,  n_out_flag;

    // shared remainder step: shift in one dividend bit, subtract if it fits
    logic [DIV_W:0]   w_trial;
    logic             w_fits;
    logic [DIV_W:0]   w_diff;
    logic [NUM_W-1:0] w_in_num;
    logic             w_in_xfer;
    logic             w_out_free;

    assign w_trial  = {r_rem, r_num[r_bit]};
    assign w_fits   = (w_trial >= {1'b0, r_div});
    assign w_diff   = w_trial - {1'b0, r_div};

    // candidate masked to the word width
    assign w_in_num  = i_cand.candidate_value[NUM_W-1:0];
    assign w_in_xfer = i_cand.valid && i_cand.ready;

    // output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_res.ready;

    assign i_cand.ready     = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.prime_flag = r_out_flag;

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_div       = r_div;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_flag  = r_out_flag;

        // result leaves on a transfer
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_num = w_in_num;
                    n_div = FIRST_DIV;
                    n_sq  = FIRST_SQ;
                    if (w_in_num < TWO) begin
                        // zero and one are not prime
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else if (!w_in_num[0]) begin
                        // even: prime only when it is two
                        n_res   = (w_in_num == TWO);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > SQ_W'(r_num)) begin
                    // no divisor up to the square root: prime
                    n_res   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_rem   = '0;
                    n_bit   = BIT_W'(NUM_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_fits ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                if (r_bit == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_NEXT: begin
                if (r_rem == '0) begin
                    // exact divisor found: composite
                    n_res   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    // (d + 2)^2 = d^2 + 4d + 4
                    n_div   = r_div + DIV_W'(2);
                    n_sq    = r_sq + SQ_W'({r_div, 2'b00}) + SQ_W'(4);
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_flag  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_div      <= n_div;
        r_sq       <= n_sq;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_res      <= n_res;
        r_out_flag <= n_out_flag;
    end

    // trial divisors stay odd while the divider runs
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_div[0])
        else $error("even trial divisor in use");

    // partial remainder is always below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_NEXT) |-> (r_rem < r_div))
        else $error("partial remainder out of range");

    // incremental square tracks the divisor
    a_sq_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_sq == SQ_W'(r_div) * SQ_W'(r_div)))
        else $error("divisor square mismatch");

    // a finished verdict is registered as soon as the output slot frees
    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=> (r_out_valid && r_out_flag == $past(r_res)))
        else $error("verdict not loaded into output register");

endmodule : trial_division_primality

`default_nettype wire

FILE: verif/trial_division_primality_tb.sv
// self-checking testbench for the trial division primality tester
`timescale 1ns / 1ps

module trial_division_primality_tb;
    import tdp_pkg::*;

    // random items are redrawn when the divider would need more trial divisors than this
    localparam int unsigned MAX_RANDOM_TRIALS = 1024;
    localparam int          NUM_RANDOM        = 78;
    localparam int          NUM_DIRECTED      = 22;
    // cycles allowed after the last verdict for a stray extra transfer to show up
    localparam int          SETTLE_CYCLES     = 40;

    // one row of the directed table: the expected flag is only used when known is set
    typedef struct packed {
        logic [CAND_W-1:0] value;
        logic              known;
        logic              flag;
    } t_directed_row;

    // one verdict waiting for its result transfer
    typedef struct {
        logic [CAND_W-1:0] value;
        bit                flag;
    } t_verdict;

    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{32'd0,          1'b1, 1'b0},  // zero is not prime
        '{32'd1,          1'b1, 1'b0},  // one is not prime
        '{32'd2,          1'b1, 1'b1},  // the only even prime
        '{32'd3,          1'b1, 1'b1},  // first odd prime, loop never runs
        '{32'd4,          1'b1, 1'b0},  // smallest even composite
        '{32'd5,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},  // divisor square equals the value
        '{32'd15,         1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0},  // caught on the second divisor, on the bound
        '{32'd49,         1'b0, 1'b0},
        '{32'd97,         1'b0, 1'b0},
        '{32'd121,        1'b0, 1'b0},
        '{32'd1001,       1'b0, 1'b0},
        '{32'd65521,      1'b0, 1'b0},  // largest 16-bit prime
        '{32'd65537,      1'b0, 1'b0},
        '{32'd16752649,   1'b0, 1'b0},  // square of a prime, found on the last divisor
        '{32'h5555_5555,  1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},  // only the top bit set, even
        '{32'hFFFF_FFFE,  1'b1, 1'b0},  // largest even value
        '{32'hFFFF_FFFF,  1'b0, 1'b0},  // all ones, divisible by three
        '{32'hFFFE_0001,  1'b0, 1'b0},  // square of the largest 16-bit value
        '{32'hFFFF_FFFB,  1'b1, 1'b1}   // largest 32-bit prime, longest run
    };

    logic clk;
    logic rst_n;

    tdp_cand_if cand_if ();
    tdp_res_if  res_if ();

    // expected flag travels with the candidate so the monitor can pick it up on transfer
    logic drv_known;
    logic drv_flag;

    t_verdict pending_verdicts [$];
    int       mismatch_count;

    trial_division_primality u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cand  (cand_if),
        .o_res   (res_if)
    );

    // odd trial divisors up to the square root, also counts how many the block will try
    function automatic bit trial_divide_is_prime(input logic [CAND_W-1:0] raw,
                                                 output int unsigned trials);
        logic [63:0] n;
        logic [63:0] d;
        n      = 64'(raw[NUM_W-1:0]);
        trials = 0;
        if (n < 64'd2)
            return 1'b0;
        if (n[0] == 1'b0)
            return n == 64'd2;
        for (d = 64'd3; d * d <= n; d += 64'd2) begin
            trials++;
            if (n % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly short gaps, some medium, a few long ones
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // spread of sizes: mostly small values so the divider stays short
    function automatic logic [CAND_W-1:0] draw_candidate();
        int unsigned r;
        int unsigned trials;
        logic [CAND_W-1:0] v;
        do begin
            r = $urandom_range(0, 99);
            if (r < 30)
                v = CAND_W'($urandom_range(0, 255));
            else if (r < 55)
                v = CAND_W'($urandom_range(0, 65535));
            else if (r < 70)
                v = CAND_W'($urandom_range(0, 1 << 20)) | CAND_W'(1);
            else if (r < 80)
                v = CAND_W'($urandom_range(1, 511) * 2 + 1)
                    * CAND_W'($urandom_range(1, 511) * 2 + 1);
            else
                v = CAND_W'($urandom());
            void'(trial_divide_is_prime(v, trials));
        end while (trials > MAX_RANDOM_TRIALS);
        return v;
    endfunction

    // one candidate transfer, entered and left at a falling edge
    task automatic send_candidate(input logic [CAND_W-1:0] value, input logic known,
                                  input logic flag, input bit drain, input bit calm);
        int unsigned gap;
        if (drain) begin
            // hold off until every verdict so far has come back
            cand_if.valid <= 1'b0;
            do @(negedge clk); while (pending_verdicts.size() != 0);
        end
        gap = pick_gap(calm);
        if (gap > 0) begin
            cand_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cand_if.valid           <= 1'b1;
        cand_if.candidate_value <= value;
        drv_known               <= known;
        drv_flag                <= flag;
        do @(posedge clk); while (!cand_if.ready);
        @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous fixed limit, well above the slowest legal run
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure: random stalls with quiet stretches in between
    initial begin
        int unsigned stall;
        int unsigned run;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                stall = 0;
                run   = $urandom_range(50, 200);
            end else begin
                stall = pick_gap(1'b0);
                run   = $urandom_range(0, 6);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            repeat (run + 1) @(negedge clk);
        end
    end

    // scoreboard: pop on a result transfer, then queue on a candidate transfer
    always @(posedge clk) begin : verdict_check
        t_verdict    exp_v;
        t_verdict    got_v;
        int unsigned unused_trials;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("prime_flag transfer with no candidate outstanding, actual %0b",
                           res_if.prime_flag);
                    mismatch_count++;
                end else begin
                    exp_v = pending_verdicts.pop_front();
                    if (res_if.prime_flag !== exp_v.flag) begin
                        $error("prime_flag mismatch for %0d: expected %0b, actual %0b",
                               exp_v.value, exp_v.flag, res_if.prime_flag);
                        mismatch_count++;
                    end
                end
            end
            if (cand_if.valid && cand_if.ready) begin
                got_v.value = cand_if.candidate_value;
                if (drv_known)
                    got_v.flag = drv_flag;
                else
                    got_v.flag = trial_divide_is_prime(cand_if.candidate_value, unused_trials);
                pending_verdicts = {pending_verdicts, got_v};
            end
        end
    end

    initial begin
        logic [CAND_W-1:0] v;
        bit calm;
        mismatch_count          = 0;
        cand_if.valid           = 1'b0;
        cand_if.candidate_value = '0;
        drv_known               = 1'b0;
        drv_flag                = 1'b0;
        rst_n                   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_candidate(DIRECTED[i].value, DIRECTED[i].known, DIRECTED[i].flag,
                           1'b0, 1'b0);

        // random part, the first item waits for the pipeline to empty
        for (int i = 0; i < NUM_RANDOM; i++) begin
            v    = draw_candidate();
            calm = (i % 25) < 6;
            send_candidate(v, 1'b0, 1'b0, (i == 0) || ($urandom_range(0, 19) == 0), calm);
        end
        cand_if.valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : trial_division_primality_tb

FILE: sim.f
sv/tdp_pkg.sv
sv/tdp_if.sv
sv/trial_division_primality.sv
verif/trial_division_primality_tb.sv
